@@ rtl/core/lcc_pkg.sv @@
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared types and constants of the local clustering coefficient engine.
// ----------------------------------------------------------------------------
package lcc_pkg;

   localparam int VERTICES = 1024;
   localparam int EDGES    = 16384;
   localparam int VIDX_W   = 10;
   localparam int EIDX_W   = 14;
   localparam int DEG_W    = 15;
   localparam int TRI_W    = 21;
   localparam int COEF_W   = 17;
   localparam int DEN_W    = 2 * DEG_W;
   localparam int NUM_W    = TRI_W + 16;
   localparam int QSTEP_W  = 6;

   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_QUERY = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [COEF_W-1:0] Q_ONE = COEF_W'(65536);

   typedef struct packed {
      logic [1:0]        req_type;
      logic [VIDX_W-1:0] source_vertex;
      logic [VIDX_W-1:0] target_vertex;
   } lcc_req_type;

   typedef struct packed {
      logic [VIDX_W-1:0] vertex_id;
      logic [TRI_W-1:0]  triangle_pairs;
      logic [DEG_W-1:0]  vertex_degree_out;
      logic [COEF_W-1:0] coefficient;
      logic              zero_denominator;
      logic              overflow_flag;
   } lcc_rsp_type;

   typedef struct packed {
      logic [EIDX_W-1:0] start;
      logic [DEG_W-1:0]  degree;
   } lcc_vtx_type;

   typedef struct packed {
      logic nbr;
      logic seen;
      logic hit;
   } lcc_mark_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_VRD, ST_VCAP,
      ST_MK_RD, ST_MK_WR,
      ST_WK_RD, ST_WK_MR, ST_WK_CHK, ST_IX_VCAP,
      ST_IX_RD, ST_IX_MR, ST_IX_CHK,
      ST_HC_RD, ST_HC_MR, ST_HC_WR, ST_WK_NEXT,
      ST_CL_RD, ST_CL_WR,
      ST_MUL, ST_DIV_GO, ST_DIV_WAIT, ST_FIN
   } lcc_state_type;

endpackage

@@ rtl/core/lcc_div.sv @@
// ----------------------------------------------------------------------------
// lcc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [lcc_pkg::NUM_W-1:0]   num,
   input  logic [lcc_pkg::DEN_W-1:0]   den,
   output logic                        done,
   output logic [lcc_pkg::NUM_W-1:0]   quo
);

   logic [lcc_pkg::NUM_W-1:0]   num_ff, num_in;
   logic [lcc_pkg::NUM_W-1:0]   quo_ff, quo_in;
   logic [lcc_pkg::DEN_W-1:0]   den_ff, den_in;
   logic [lcc_pkg::DEN_W-1:0]   rem_ff, rem_in;
   logic [lcc_pkg::QSTEP_W-1:0] cnt_ff, cnt_in;
   logic                        run_ff, run_in;
   logic                        done_ff, done_in;
   logic [lcc_pkg::DEN_W:0]     trial;

   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[lcc_pkg::NUM_W-1]};
      if (go) begin
         num_in = num;
         den_in = den;
         rem_in = '0;
         quo_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         num_in = {num_ff[lcc_pkg::NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = lcc_pkg::DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[lcc_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[lcc_pkg::DEN_W-1:0];
            quo_in = {quo_ff[lcc_pkg::NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == lcc_pkg::QSTEP_W'(lcc_pkg::NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

@@ rtl/core/local_clustering_coefficient.sv @@
// ----------------------------------------------------------------------------
// local_clustering_coefficient
// Edge list loader and per-vertex clustering coefficient query engine.
//
//   channel  direction  handshake           payload
//   request  in         start / busy        req_data  (lcc_req_type)
//   result   out        rsp_valid strobe    rsp_data  (lcc_rsp_type)
//
// A load or clear transaction is accepted from the idle state; loads may follow
// back to back. A query marks the neighbors of the vertex, walks each distinct
// neighbor w and its edge list, cleans up the marks, finishes, and runs the
// divider when the count is nonzero and the degree is two or more; a vertex
// without edges goes straight to finish. The result strobes in the cycle after
// the finish state. Reset and clear run a clearing pass over the vertex and
// mark memories with busy high. The receiver cannot stall.
// ----------------------------------------------------------------------------
module local_clustering_coefficient (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  lcc_pkg::lcc_req_type req_data,
   output logic                 rsp_valid,
   output lcc_pkg::lcc_rsp_type rsp_data
);

   localparam int VW = lcc_pkg::VIDX_W;
   localparam int EW = lcc_pkg::EIDX_W;
   localparam int DW = lcc_pkg::DEG_W;

   logic [VW-1:0]          e_mem [lcc_pkg::EDGES];
   lcc_pkg::lcc_vtx_type   v_mem [lcc_pkg::VERTICES];
   lcc_pkg::lcc_mark_type  m_mem [lcc_pkg::VERTICES];

   lcc_pkg::lcc_state_type state_ff, state_in;

   logic [VW-1:0] e_q_ff;
   lcc_pkg::lcc_vtx_type  v_q_ff;
   lcc_pkg::lcc_mark_type m_q_ff;

   logic [EW-1:0] e_raddr;
   logic [VW-1:0] v_raddr, m_raddr;
   logic          e_we, v_we, m_we;
   logic [EW-1:0] e_waddr;
   logic [VW-1:0] e_wdata, v_waddr, m_waddr;
   lcc_pkg::lcc_vtx_type  v_wdata;
   lcc_pkg::lcc_mark_type m_wdata;

   logic [DW-1:0]   edges_ff;
   logic [VW-1:0]   last_ff;
   logic            last_valid_ff;
   logic            err_ff;
   logic [EW-1:0]   cur_start_ff;
   logic [DW-1:0]   cur_deg_ff;
   logic [VW-1:0]   clr_ff;

   logic [VW-1:0]   v_ff, w_ff, x_ff;
   logic [EW-1:0]   s_ff, s2_ff;
   logic [DW-1:0]   n_ff, n2_ff, i_ff, j_ff;
   logic [lcc_pkg::TRI_W-1:0] t_ff;
   logic [lcc_pkg::DEN_W-1:0] den_ff;
   logic            rsp_valid_ff;
   lcc_pkg::lcc_rsp_type rsp_ff;

   logic accept, is_load, load_ok, new_src, i_last, j_last;
   logic [EW-1:0] ld_start;
   logic [DW-1:0] ld_deg;
   logic div_done;
   logic [lcc_pkg::NUM_W-1:0] div_quo;
   logic [lcc_pkg::COEF_W-1:0] coef;

   assign accept  = start && (state_ff == lcc_pkg::ST_IDLE);
   assign is_load = accept && (req_data.req_type == lcc_pkg::REQ_LOAD);
   assign load_ok = (edges_ff != DW'(lcc_pkg::EDGES)) &&
                    !(last_valid_ff && (req_data.source_vertex < last_ff));
   assign new_src = !last_valid_ff || (req_data.source_vertex != last_ff);
   assign ld_start = new_src ? edges_ff[EW-1:0] : cur_start_ff;
   assign ld_deg   = new_src ? DW'(1) : DW'(cur_deg_ff + 1'b1);
   assign i_last  = (DW'(i_ff + 1'b1) == n_ff);
   assign j_last  = (DW'(j_ff + 1'b1) == n2_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lcc_pkg::ST_CLEAR:
            if (clr_ff == VW'(lcc_pkg::VERTICES - 1)) state_in = lcc_pkg::ST_IDLE;
         lcc_pkg::ST_IDLE:
            if (accept) begin
               if (req_data.req_type == lcc_pkg::REQ_QUERY) state_in = lcc_pkg::ST_VRD;
               else if (req_data.req_type == lcc_pkg::REQ_CLEAR) state_in = lcc_pkg::ST_CLEAR;
            end
         lcc_pkg::ST_VRD:  state_in = lcc_pkg::ST_VCAP;
         lcc_pkg::ST_VCAP:
            state_in = (v_q_ff.degree == '0) ? lcc_pkg::ST_FIN : lcc_pkg::ST_MK_RD;
         lcc_pkg::ST_MK_RD: state_in = lcc_pkg::ST_MK_WR;
         lcc_pkg::ST_MK_WR: state_in = i_last ? lcc_pkg::ST_WK_RD : lcc_pkg::ST_MK_RD;
         lcc_pkg::ST_WK_RD: state_in = lcc_pkg::ST_WK_MR;
         lcc_pkg::ST_WK_MR: state_in = lcc_pkg::ST_WK_CHK;
         lcc_pkg::ST_WK_CHK:
            state_in = m_q_ff.seen ? lcc_pkg::ST_WK_NEXT : lcc_pkg::ST_IX_VCAP;
         lcc_pkg::ST_IX_VCAP:
            state_in = (v_q_ff.degree == '0) ? lcc_pkg::ST_WK_NEXT : lcc_pkg::ST_IX_RD;
         lcc_pkg::ST_IX_RD:  state_in = lcc_pkg::ST_IX_MR;
         lcc_pkg::ST_IX_MR:  state_in = lcc_pkg::ST_IX_CHK;
         lcc_pkg::ST_IX_CHK: state_in = j_last ? lcc_pkg::ST_HC_RD : lcc_pkg::ST_IX_RD;
         lcc_pkg::ST_HC_RD:  state_in = lcc_pkg::ST_HC_MR;
         lcc_pkg::ST_HC_MR:  state_in = lcc_pkg::ST_HC_WR;
         lcc_pkg::ST_HC_WR:  state_in = j_last ? lcc_pkg::ST_WK_NEXT : lcc_pkg::ST_HC_RD;
         lcc_pkg::ST_WK_NEXT: state_in = i_last ? lcc_pkg::ST_CL_RD : lcc_pkg::ST_WK_RD;
         lcc_pkg::ST_CL_RD:  state_in = lcc_pkg::ST_CL_WR;
         lcc_pkg::ST_CL_WR:  state_in = i_last ? lcc_pkg::ST_MUL : lcc_pkg::ST_CL_RD;
         lcc_pkg::ST_MUL:
            state_in = ((t_ff != '0) && (n_ff >= DW'(2))) ? lcc_pkg::ST_DIV_GO
                                                          : lcc_pkg::ST_FIN;
         lcc_pkg::ST_DIV_GO:   state_in = lcc_pkg::ST_DIV_WAIT;
         lcc_pkg::ST_DIV_WAIT: if (div_done) state_in = lcc_pkg::ST_FIN;
         lcc_pkg::ST_FIN:      state_in = lcc_pkg::ST_IDLE;
         default:              state_in = lcc_pkg::ST_CLEAR;
      endcase
   end

   // memory control
   always_comb begin
      e_raddr = s_ff + i_ff[EW-1:0];
      v_raddr = v_ff;
      m_raddr = e_q_ff;
      e_we    = 1'b0;
      e_waddr = edges_ff[EW-1:0];
      e_wdata = req_data.target_vertex;
      v_we    = 1'b0;
      v_waddr = req_data.source_vertex;
      v_wdata = '{start: ld_start, degree: ld_deg};
      m_we    = 1'b0;
      m_waddr = e_q_ff;
      m_wdata = '0;
      case (state_ff)
         lcc_pkg::ST_CLEAR: begin
            v_we    = 1'b1;
            v_waddr = clr_ff;
            v_wdata = '0;
            m_we    = 1'b1;
            m_waddr = clr_ff;
         end
         lcc_pkg::ST_IDLE: begin
            e_we = is_load && load_ok;
            v_we = is_load && load_ok;
         end
         lcc_pkg::ST_MK_WR: begin
            m_we    = 1'b1;
            m_wdata = '{nbr: 1'b1, seen: 1'b0, hit: 1'b0};
         end
         lcc_pkg::ST_WK_CHK: begin
            v_raddr = w_ff;
            m_we    = !m_q_ff.seen;
            m_waddr = w_ff;
            m_wdata = '{nbr: m_q_ff.nbr, seen: 1'b1, hit: m_q_ff.hit};
         end
         lcc_pkg::ST_IX_RD, lcc_pkg::ST_HC_RD: e_raddr = s2_ff + j_ff[EW-1:0];
         lcc_pkg::ST_IX_CHK: begin
            m_we    = m_q_ff.nbr && !m_q_ff.hit;
            m_waddr = x_ff;
            m_wdata = '{nbr: m_q_ff.nbr, seen: m_q_ff.seen, hit: 1'b1};
         end
         lcc_pkg::ST_HC_WR: begin
            m_we    = 1'b1;
            m_waddr = x_ff;
            m_wdata = '{nbr: m_q_ff.nbr, seen: m_q_ff.seen, hit: 1'b0};
         end
         lcc_pkg::ST_CL_WR: m_we = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (e_we) e_mem[e_waddr] <= e_wdata;
      e_q_ff <= e_mem[e_raddr];
   end

   always_ff @(posedge clock) begin
      if (v_we) v_mem[v_waddr] <= v_wdata;
      v_q_ff <= v_mem[v_raddr];
   end

   always_ff @(posedge clock) begin
      if (m_we) m_mem[m_waddr] <= m_wdata;
      m_q_ff <= m_mem[m_raddr];
   end

   lcc_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (state_ff == lcc_pkg::ST_DIV_GO),
      .num   ({t_ff, 16'b0}),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign coef = (div_quo > lcc_pkg::NUM_W'(lcc_pkg::Q_ONE)) ? lcc_pkg::Q_ONE
                                                              : div_quo[lcc_pkg::COEF_W-1:0];

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         lcc_pkg::ST_IDLE: begin
            v_ff <= req_data.source_vertex;
            t_ff <= '0;
         end
         lcc_pkg::ST_VCAP: begin
            s_ff <= v_q_ff.start;
            n_ff <= v_q_ff.degree;
            i_ff <= '0;
         end
         lcc_pkg::ST_MK_WR, lcc_pkg::ST_WK_NEXT, lcc_pkg::ST_CL_WR:
            i_ff <= i_last ? '0 : DW'(i_ff + 1'b1);
         lcc_pkg::ST_WK_MR: w_ff <= e_q_ff;
         lcc_pkg::ST_IX_VCAP: begin
            s2_ff <= v_q_ff.start;
            n2_ff <= v_q_ff.degree;
            j_ff  <= '0;
         end
         lcc_pkg::ST_IX_MR, lcc_pkg::ST_HC_MR: x_ff <= e_q_ff;
         lcc_pkg::ST_IX_CHK: begin
            if (m_q_ff.nbr && !m_q_ff.hit) t_ff <= t_ff + 1'b1;
            j_ff <= j_last ? '0 : DW'(j_ff + 1'b1);
         end
         lcc_pkg::ST_HC_WR: j_ff <= DW'(j_ff + 1'b1);
         lcc_pkg::ST_MUL: den_ff <= n_ff * DW'(n_ff - 1'b1);
         lcc_pkg::ST_FIN: begin
            rsp_ff.vertex_id         <= v_ff;
            rsp_ff.triangle_pairs    <= t_ff;
            rsp_ff.vertex_degree_out <= n_ff;
            rsp_ff.zero_denominator  <= (t_ff != '0) && (n_ff < DW'(2));
            rsp_ff.coefficient       <= ((t_ff != '0) && (n_ff >= DW'(2))) ? coef : '0;
            rsp_ff.overflow_flag     <= err_ff;
         end
         default: ;
      endcase
      if (state_ff == lcc_pkg::ST_VRD) n_ff <= '0;
      if (is_load && load_ok) begin
         cur_start_ff <= ld_start;
         cur_deg_ff   <= ld_deg;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lcc_pkg::ST_CLEAR;
         clr_ff        <= '0;
         edges_ff      <= '0;
         last_ff       <= '0;
         last_valid_ff <= 1'b0;
         err_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == lcc_pkg::ST_FIN);
         if (state_ff == lcc_pkg::ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (accept && (req_data.req_type == lcc_pkg::REQ_CLEAR)) begin
            clr_ff        <= '0;
            edges_ff      <= '0;
            last_valid_ff <= 1'b0;
            err_ff        <= 1'b0;
         end
         if (is_load) begin
            if (load_ok) begin
               edges_ff      <= edges_ff + 1'b1;
               last_ff       <= req_data.source_vertex;
               last_valid_ff <= 1'b1;
            end else begin
               err_ff <= 1'b1;
            end
         end
      end
   end

   assign busy      = (state_ff != lcc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
